// File: hw/rtl/lgi_pkg.sv
// shared types and constants of the limited gap interpolator
`default_nettype none

package lgi_pkg;

  localparam int VALUE_W = 16;
  localparam int POS_W = 6;
  localparam int LEN_W = 7;
  localparam int FILL_W = 7;

  localparam int WINDOW_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_FILL_LIMIT = 1'b0;
  localparam logic [FILL_W-1:0] FILL_LIMIT_RESET = 7'd8;

  // rounded quotient (2*mag*step + den) / (2*den)
  localparam int DIV_DIVIDEND_W = 23;
  localparam int DIV_DIVISOR_W = 8;
  localparam int DIV_STEPS = DIV_DIVIDEND_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic signed [VALUE_W-1:0] left;
    logic left_ok;
    logic signed [VALUE_W-1:0] right;
    logic right_ok;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GAP,
    B_DIV,
    B_EMIT,
    B_SAMPLE
  } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/lgi_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module lgi_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [lgi_pkg::DIV_DIVIDEND_W-1:0]   dividend,
  input  wire logic [lgi_pkg::DIV_DIVISOR_W-1:0]    divisor,
  output logic                                      done,
  output logic [lgi_pkg::VALUE_W-1:0]               quotient
);

  logic                                busy;
  logic [lgi_pkg::DIV_CNT_W-1:0]       cnt;
  logic [lgi_pkg::DIV_DIVISOR_W-1:0]   rem;
  logic [lgi_pkg::DIV_DIVIDEND_W-1:0]  dq;
  logic [lgi_pkg::DIV_DIVISOR_W-1:0]   dvs;

  logic [lgi_pkg::DIV_DIVISOR_W:0]     shifted;
  logic                                fits;
  logic [lgi_pkg::DIV_DIVISOR_W:0]     trial;

  always_comb begin
    shifted = {rem, dq[lgi_pkg::DIV_DIVIDEND_W-1]};
    trial = shifted - {1'b0, dvs};
    fits = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == lgi_pkg::DIV_CNT_W'(lgi_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[lgi_pkg::DIV_DIVISOR_W-1:0] : shifted[lgi_pkg::DIV_DIVISOR_W-1:0];
      dq <= {dq[lgi_pkg::DIV_DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = dq[lgi_pkg::VALUE_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/lgi_front.sv
// front end: tracks the window and turns samples into release commands
`default_nettype none

module lgi_front #(
  parameter int WINDOW = lgi_pkg::WINDOW_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [lgi_pkg::VALUE_W-1:0] sample,
  input  wire logic                               sample_finite,
  input  wire logic                               q_full,
  output logic                                    push,
  output lgi_pkg::cmd_t                           push_cmd
);

  logic [lgi_pkg::POS_W-1:0]          sample_index;
  logic [lgi_pkg::LEN_W-1:0]          gap_length;
  logic signed [lgi_pkg::VALUE_W-1:0] left_value;
  logic                               left_present;

  logic accept;
  logic at_end;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign at_end = sample_index == lgi_pkg::POS_W'(WINDOW - 1);
  assign push = accept && (sample_finite || at_end);

  always_comb begin
    push_cmd.start = sample_index - gap_length[lgi_pkg::POS_W-1:0];
    push_cmd.len = sample_finite ? gap_length : gap_length + 1'b1;
    push_cmd.left = left_value;
    push_cmd.left_ok = left_present;
    push_cmd.right = sample;
    push_cmd.right_ok = sample_finite;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      gap_length <= '0;
      left_value <= '0;
      left_present <= 1'b0;
    end else if (accept) begin
      if (at_end) begin
        sample_index <= '0;
        gap_length <= '0;
        left_value <= '0;
        left_present <= 1'b0;
      end else begin
        sample_index <= sample_index + 1'b1;
        if (sample_finite) begin
          gap_length <= '0;
          left_value <= sample;
          left_present <= 1'b1;
        end else begin
          gap_length <= gap_length + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lgi_queue.sv
// short command queue between front and back end
`default_nettype none

module lgi_queue #(
  parameter int DEPTH = lgi_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lgi_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output lgi_pkg::cmd_t      pop_data,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lgi_pkg::cmd_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  logic do_push;
  logic do_pop;

  assign full = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lgi_back.sv
// back end: walks each command, fills gap positions and drives the result register
`default_nettype none

module lgi_back #(
  parameter int WINDOW = lgi_pkg::WINDOW_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [lgi_pkg::FILL_W-1:0]         fill_limit,
  input  wire lgi_pkg::cmd_t                      pop_data,
  input  wire logic                               q_empty,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [lgi_pkg::VALUE_W-1:0]      value,
  output logic                                    value_valid,
  output logic [lgi_pkg::POS_W-1:0]               position,
  output logic                                    burst_last,
  output logic                                    window_last
);

  lgi_pkg::back_state_t state;
  lgi_pkg::back_state_t state_next;

  lgi_pkg::cmd_t                      cmd;
  logic [lgi_pkg::VALUE_W-1:0]        mag;
  logic                               neg;
  logic [lgi_pkg::LEN_W-1:0]          k;
  logic signed [lgi_pkg::VALUE_W-1:0] res_value;
  logic                               res_valid;

  logic [lgi_pkg::VALUE_W:0]          diff;
  logic [lgi_pkg::VALUE_W:0]          diff_neg;

  logic [lgi_pkg::LEN_W-1:0]          step;
  logic [lgi_pkg::LEN_W-1:0]          den;
  logic [lgi_pkg::LEN_W-1:0]          from_right;
  logic                               near_left;
  logic                               near_right;
  logic                               both;
  logic                               need_div;
  logic                               last_k;
  logic                               slot_free;
  logic [21:0]                        prod;
  logic [lgi_pkg::DIV_DIVIDEND_W-1:0] dividend;
  logic [lgi_pkg::DIV_DIVISOR_W-1:0]  divisor;
  logic                               div_start;
  logic                               div_done;
  logic [lgi_pkg::VALUE_W-1:0]        quotient;

  logic                               res_load;
  logic signed [lgi_pkg::VALUE_W-1:0] res_value_next;
  logic                               res_valid_next;
  logic                               k_step;
  logic                               load_out;
  logic signed [lgi_pkg::VALUE_W-1:0] value_next;
  logic                               value_valid_next;
  logic [lgi_pkg::POS_W-1:0]          position_next;
  logic                               burst_last_next;

  always_comb begin
    diff = {pop_data.right[lgi_pkg::VALUE_W-1], pop_data.right}
         - {pop_data.left[lgi_pkg::VALUE_W-1], pop_data.left};
    diff_neg = -diff;
  end

  always_comb begin
    step = k + 1'b1;
    den = cmd.len + 1'b1;
    from_right = cmd.len - 1'b1 - k;
    near_left = k < fill_limit;
    near_right = from_right < fill_limit;
    both = cmd.left_ok && cmd.right_ok;
    need_div = both && (near_left || near_right);
    last_k = k == cmd.len - 1'b1;
    slot_free = !out_valid || !out_stall;
    prod = 22'(mag) * 22'(step);
    dividend = {prod, 1'b0} + lgi_pkg::DIV_DIVIDEND_W'(den);
    divisor = {den, 1'b0};
  end

  lgi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lgi_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_next = (pop_data.len == '0) ? lgi_pkg::B_SAMPLE : lgi_pkg::B_GAP;
        end
      end
      lgi_pkg::B_GAP: begin
        state_next = need_div ? lgi_pkg::B_DIV : lgi_pkg::B_EMIT;
      end
      lgi_pkg::B_DIV: begin
        if (div_done) begin
          state_next = lgi_pkg::B_EMIT;
        end
      end
      lgi_pkg::B_EMIT: begin
        if (slot_free) begin
          if (!last_k) begin
            state_next = lgi_pkg::B_GAP;
          end else if (cmd.right_ok) begin
            state_next = lgi_pkg::B_SAMPLE;
          end else begin
            state_next = lgi_pkg::B_IDLE;
          end
        end
      end
      lgi_pkg::B_SAMPLE: begin
        if (slot_free) begin
          state_next = lgi_pkg::B_IDLE;
        end
      end
      default: state_next = lgi_pkg::B_IDLE;
    endcase
  end

  // controls
  always_comb begin
    pop = 1'b0;
    div_start = 1'b0;
    res_load = 1'b0;
    res_value_next = '0;
    res_valid_next = 1'b0;
    k_step = 1'b0;
    load_out = 1'b0;
    value_next = res_value;
    value_valid_next = res_valid;
    position_next = cmd.start + k[lgi_pkg::POS_W-1:0];
    burst_last_next = last_k && !cmd.right_ok;
    unique case (state)
      lgi_pkg::B_IDLE: begin
        pop = !q_empty;
      end
      lgi_pkg::B_GAP: begin
        if (need_div) begin
          div_start = 1'b1;
        end else begin
          res_load = 1'b1;
          if (cmd.left_ok && !cmd.right_ok && near_left) begin
            res_value_next = cmd.left;
            res_valid_next = 1'b1;
          end else if (!cmd.left_ok && cmd.right_ok && near_right) begin
            res_value_next = cmd.right;
            res_valid_next = 1'b1;
          end
        end
      end
      lgi_pkg::B_DIV: begin
        if (div_done) begin
          res_load = 1'b1;
          res_valid_next = 1'b1;
          res_value_next = neg ? cmd.left - $signed(quotient) : cmd.left + $signed(quotient);
        end
      end
      lgi_pkg::B_EMIT: begin
        load_out = slot_free;
        k_step = slot_free;
      end
      lgi_pkg::B_SAMPLE: begin
        load_out = slot_free;
        value_next = cmd.right;
        value_valid_next = 1'b1;
        position_next = cmd.start + cmd.len[lgi_pkg::POS_W-1:0];
        burst_last_next = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lgi_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= pop_data;
      neg <= diff[lgi_pkg::VALUE_W];
      mag <= diff[lgi_pkg::VALUE_W] ? diff_neg[lgi_pkg::VALUE_W-1:0]
                                    : diff[lgi_pkg::VALUE_W-1:0];
      k <= '0;
    end else if (k_step) begin
      k <= k + 1'b1;
    end
    if (res_load) begin
      res_value <= res_value_next;
      res_valid <= res_valid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value <= value_valid_next ? value_next : '0;
      value_valid <= value_valid_next;
      position <= position_next;
      burst_last <= burst_last_next;
      window_last <= position_next == lgi_pkg::POS_W'(WINDOW - 1);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/limited_gap_interpolator_core.sv
// top level of the limited gap interpolator: register port, front end, queue, back end
// a finite sample after no gap passes the command queue, the back end's command register
// and the result register; each gap position adds the back end's gap and emit states and,
// when interpolated, a wait on the bit-serial divider in the back end (23 quotient bits)
// the front end takes a request each cycle while the command queue has room
// synchronous reset clears the window state, queue, result valid flag and sets fill_limit to 8
`default_nettype none

module limited_gap_interpolator_core #(
  parameter int WINDOW = lgi_pkg::WINDOW_DEF,
  parameter int QUEUE_DEPTH = lgi_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lgi_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [lgi_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [lgi_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                     pready,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [lgi_pkg::VALUE_W-1:0]  sample,
  input  wire logic                                sample_finite,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [lgi_pkg::VALUE_W-1:0]       value,
  output logic                                     value_valid,
  output logic [lgi_pkg::POS_W-1:0]                position,
  output logic                                     burst_last,
  output logic                                     window_last
);

  logic [lgi_pkg::FILL_W-1:0] fill_limit;
  logic [0:0]                 reg_index;
  logic                       cfg_write;

  logic           push;
  lgi_pkg::cmd_t  push_cmd;
  logic           q_full;
  logic           pop;
  lgi_pkg::cmd_t  pop_data;
  logic           q_empty;

  assign pready = 1'b1;
  assign reg_index = paddr[lgi_pkg::CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (reg_index == lgi_pkg::REG_FILL_LIMIT)
                ? lgi_pkg::CFG_DATA_W'(fill_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_limit <= lgi_pkg::FILL_LIMIT_RESET;
    end else if (cfg_write && reg_index == lgi_pkg::REG_FILL_LIMIT) begin
      fill_limit <= pwdata[lgi_pkg::FILL_W-1:0];
    end
  end

  lgi_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .sample_finite (sample_finite),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  lgi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  lgi_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .fill_limit  (fill_limit),
    .pop_data    (pop_data),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .value_valid (value_valid),
    .position    (position),
    .burst_last  (burst_last),
    .window_last (window_last)
  );

  // no command is pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) q_full |-> !push)
    else $error("command pushed into full queue");

  // the final position of a window always closes its burst
  assert property (@(posedge clk) disable iff (rst) (out_valid && window_last) |-> burst_last)
    else $error("window end without burst end");

  // unfilled positions carry a zero value
  assert property (@(posedge clk) disable iff (rst) (out_valid && !value_valid) |-> value == '0)
    else $error("unfilled position with non-zero value");

endmodule

`default_nettype wire
